>>> rtl/core/assert_macros.svh
// Assertion macros shared by the solver RTL.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C3S_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("solver assertion failed");
`define C3S_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("solver assertion failed");
`else
`define C3S_ASSERT_IMPLY(label, clk, rst, pre, post)
`define C3S_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> rtl/core/c3s_pkg.sv
// Shared widths, types and the divider step for the 3x3 Cramer solver.
// No dependencies.
`default_nettype none
package c3s_pkg;
   localparam int unsigned FIELD_W      = 32;
   localparam int unsigned PROD_W       = 64;
   localparam int unsigned CROSS_W      = 65;
   localparam int unsigned PART_W       = 65;
   localparam int unsigned TRI_W        = 98;
   localparam int unsigned MAG_W        = 98;
   localparam int unsigned DIV_STEPS    = 32;
   localparam int unsigned FRONT_STAGES = 7;
   localparam logic [FIELD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [FIELD_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic signed [FIELD_W-1:0] c3s_word_type;

   // One unknown on its way through the restoring divider.
   typedef struct packed {
      logic [MAG_W-1:0]   rem;
      logic [MAG_W-1:0]   den;
      logic [FIELD_W-1:0] quo;
      logic [FIELD_W-1:0] nlo;
   } c3s_lane_type;

   typedef struct packed {
      logic       singular;
      logic [2:0] neg;
      logic [2:0] ovf;
   } c3s_ctl_type;

   // One quotient bit: shift in the next numerator bit and subtract if it fits.
   function automatic c3s_lane_type div_step(c3s_lane_type x);
      logic [MAG_W+1:0] diff;
      logic             fits;
      c3s_lane_type     y;
      diff = {1'b0, x.rem, x.nlo[FIELD_W-1]} - {2'b00, x.den};
      fits = !diff[MAG_W+1];
      y.rem = fits ? diff[MAG_W-1:0] : {x.rem[MAG_W-2:0], x.nlo[FIELD_W-1]};
      y.den = x.den;
      y.quo = {x.quo[FIELD_W-2:0], fits};
      y.nlo = {x.nlo[FIELD_W-2:0], 1'b0};
      return y;
   endfunction
endpackage
`default_nettype wire

>>> rtl/core/c3s_if.sv
// Valid/ready channel interfaces for the solver's request and response.
// Depends on c3s_pkg.
`default_nettype none
interface c3s_req_if;
   logic                  valid;
   logic                  ready;
   c3s_pkg::c3s_word_type target_x, target_y, target_z;
   c3s_pkg::c3s_word_type col_a_x, col_a_y, col_a_z;
   c3s_pkg::c3s_word_type col_b_x, col_b_y, col_b_z;
   c3s_pkg::c3s_word_type col_c_x, col_c_y, col_c_z;
   modport source (output valid, target_x, target_y, target_z, col_a_x, col_a_y, col_a_z,
                   col_b_x, col_b_y, col_b_z, col_c_x, col_c_y, col_c_z, input ready);
   modport sink (input valid, target_x, target_y, target_z, col_a_x, col_a_y, col_a_z,
                 col_b_x, col_b_y, col_b_z, col_c_x, col_c_y, col_c_z, output ready);
endinterface

interface c3s_rsp_if;
   logic                  valid;
   logic                  ready;
   c3s_pkg::c3s_word_type sol_x, sol_y, sol_z;
   logic                  singular;
   modport source (output valid, sol_x, sol_y, sol_z, singular, input ready);
   modport sink (input valid, sol_x, sol_y, sol_z, singular, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cramer_3x3_solver.sv
// Cramer's-rule 3x3 solver, pipelined from request transfer to response.
// Throughput one system per cycle; each stage holds when its successor is full.
// Stages: 7 for products, sums, magnitudes and divider setup, 32 divider steps
// (one quotient bit each), one output register. Synchronous active-high reset
// empties the pipeline; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"
module cramer_3x3_solver (
   input  wire logic  clock,
   input  wire logic  reset,
   c3s_req_if.sink    req,
   c3s_rsp_if.source  rsp
);
   localparam int unsigned NF  = c3s_pkg::FRONT_STAGES;
   localparam int unsigned W   = c3s_pkg::FIELD_W;
   localparam int unsigned TW  = c3s_pkg::TRI_W;
   localparam int unsigned MW  = c3s_pkg::MAG_W;

   logic [NF:1]   vld_ff;
   logic [NF:1]   vld_in;
   logic [NF+1:1] adv;
   logic          div_in_ready;

   assign adv[NF+1] = div_in_ready;
   for (genvar k = 1; k <= NF; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end
   assign vld_in    = {vld_ff[NF-1:1], req.valid};
   assign req.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (adv[NF:1] & vld_in) | (~adv[NF:1] & vld_ff);
      end
   end

   // Stage 1: the eighteen products of the cross products B x C, T x C, B x T.
   logic signed [W-1:0] vt [3], va [3], vb [3], vc [3];
   assign vt[0] = req.target_x;
   assign vt[1] = req.target_y;
   assign vt[2] = req.target_z;
   assign va[0] = req.col_a_x;
   assign va[1] = req.col_a_y;
   assign va[2] = req.col_a_z;
   assign vb[0] = req.col_b_x;
   assign vb[1] = req.col_b_y;
   assign vb[2] = req.col_b_z;
   assign vc[0] = req.col_c_x;
   assign vc[1] = req.col_c_y;
   assign vc[2] = req.col_c_z;

   logic signed [c3s_pkg::PROD_W-1:0] mul_in [3][3][2];
   logic signed [c3s_pkg::PROD_W-1:0] mul_ff [3][3][2];
   logic signed [W-1:0]               t1_ff [3], a1_ff [3];

   for (genvar i = 0; i < 3; i++) begin : g_cross_mul
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      assign mul_in[0][i][0] = vb[I1] * vc[I2];
      assign mul_in[0][i][1] = vb[I2] * vc[I1];
      assign mul_in[1][i][0] = vt[I1] * vc[I2];
      assign mul_in[1][i][1] = vt[I2] * vc[I1];
      assign mul_in[2][i][0] = vb[I1] * vt[I2];
      assign mul_in[2][i][1] = vb[I2] * vt[I1];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         mul_ff <= mul_in;
         t1_ff  <= vt;
         a1_ff  <= va;
      end
   end

   // Stage 2: cross product components.
   logic signed [c3s_pkg::CROSS_W-1:0] cross_ff [3][3];
   logic signed [W-1:0]                t2_ff [3], a2_ff [3];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               cross_ff[k][i] <= c3s_pkg::CROSS_W'(mul_ff[k][i][0])
                               - c3s_pkg::CROSS_W'(mul_ff[k][i][1]);
            end
         end
         t2_ff <= t1_ff;
         a2_ff <= a1_ff;
      end
   end

   // Stage 3: dot products split into 32 x 33 partial products.
   // Triple 0 is the determinant, triples 1 to 3 the numerators.
   logic signed [c3s_pkg::PART_W-1:0] part_in [4][3][2];
   logic signed [c3s_pkg::PART_W-1:0] part_ff [4][3][2];

   for (genvar j = 0; j < 4; j++) begin : g_dot
      localparam int CK = (j == 0) ? 0 : j - 1;
      for (genvar i = 0; i < 3; i++) begin : g_term
         logic signed [W-1:0]                p;
         logic signed [c3s_pkg::CROSS_W-1:0] cr;
         assign p  = (j == 1) ? t2_ff[i] : a2_ff[i];
         assign cr = cross_ff[CK][i];
         assign part_in[j][i][0] = p * $signed({1'b0, cr[W-1:0]});
         assign part_in[j][i][1] = p * $signed(cr[c3s_pkg::CROSS_W-1:W]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         part_ff <= part_in;
      end
   end

   // Stage 4: rejoin the partial products.
   logic signed [TW-1:0] term_ff [4][3];
   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int j = 0; j < 4; j++) begin
            for (int i = 0; i < 3; i++) begin
               term_ff[j][i] <= (TW'(part_ff[j][i][1]) <<< W) + TW'(part_ff[j][i][0]);
            end
         end
      end
   end

   // Stage 5: triple products.
   logic signed [TW-1:0] tri_ff [4];
   always_ff @(posedge clock) begin
      if (adv[5]) begin
         for (int j = 0; j < 4; j++) begin
            tri_ff[j] <= term_ff[j][0] + term_ff[j][1] + term_ff[j][2];
         end
      end
   end

   // Stage 6: signs and magnitudes.
   logic [3:0]    sgn6_ff;
   logic [MW-1:0] mag6_ff [4];
   logic          sing6_ff;
   always_ff @(posedge clock) begin
      if (adv[6]) begin
         for (int j = 0; j < 4; j++) begin
            sgn6_ff[j] <= tri_ff[j][TW-1];
            mag6_ff[j] <= tri_ff[j][TW-1] ? MW'(-tri_ff[j]) : MW'(tri_ff[j]);
         end
         sing6_ff <= (tri_ff[0] == '0);
      end
   end

   // Stage 7: divider setup. The quotient needs more than 32 bits exactly when
   // |N| >= |D| * 2^16; otherwise the upper numerator bits are below |D|.
   c3s_pkg::c3s_lane_type [2:0] lane7_ff;
   c3s_pkg::c3s_ctl_type        ctl7_ff;
   always_ff @(posedge clock) begin
      if (adv[7]) begin
         for (int l = 0; l < 3; l++) begin
            lane7_ff[l].rem <= MW'(mag6_ff[l+1][MW-1:16]);
            lane7_ff[l].den <= mag6_ff[0];
            lane7_ff[l].quo <= '0;
            lane7_ff[l].nlo <= {mag6_ff[l+1][15:0], 16'h0000};
            ctl7_ff.ovf[l]  <= {16'h0000, mag6_ff[l+1]} >= {mag6_ff[0], 16'h0000};
            ctl7_ff.neg[l]  <= sgn6_ff[l+1] ^ sgn6_ff[0];
         end
         ctl7_ff.singular <= sing6_ff;
      end
   end

   logic                    div_out_valid;
   logic                    out_adv;
   logic [2:0][W-1:0]       div_quo;
   c3s_pkg::c3s_ctl_type    div_ctl;

   c3s_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[NF]),
      .in_ready  (div_in_ready),
      .in_lane   (lane7_ff),
      .in_ctl    (ctl7_ff),
      .out_valid (div_out_valid),
      .out_ready (out_adv),
      .out_quo   (div_quo),
      .out_ctl   (div_ctl)
   );

   // Output register: sign, saturation and the singular case.
   logic [W-1:0] sol_in [3];
   logic [W-1:0] sol_ff [3];
   logic         rsp_vld_ff;
   logic         rsp_sing_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         if (div_ctl.singular) begin
            sol_in[l] = '0;
         end else if (div_ctl.neg[l]) begin
            sol_in[l] = (div_ctl.ovf[l] || div_quo[l] > c3s_pkg::SAT_NEG)
                      ? c3s_pkg::SAT_NEG : -div_quo[l];
         end else begin
            sol_in[l] = (div_ctl.ovf[l] || div_quo[l][W-1]) ? c3s_pkg::SAT_POS : div_quo[l];
         end
      end
   end

   assign out_adv = !rsp_vld_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_vld_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         sol_ff      <= sol_in;
         rsp_sing_ff <= div_ctl.singular;
      end
   end

   assign rsp.valid    = rsp_vld_ff;
   assign rsp.sol_x    = sol_ff[0];
   assign rsp.sol_y    = sol_ff[1];
   assign rsp.sol_z    = sol_ff[2];
   assign rsp.singular = rsp_sing_ff;

   `C3S_ASSERT_IMPLY(a_singular_zero, clock, reset, rsp_vld_ff && rsp_sing_ff, sol_ff[0] == '0 && sol_ff[1] == '0 && sol_ff[2] == '0)
   `C3S_ASSERT_NEXT(a_transfer_enters, clock, reset, req.valid && req.ready, vld_ff[1])
   `C3S_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_vld_ff && vld_ff == '0)
endmodule
`default_nettype wire

>>> rtl/core/c3s_div_pipe.sv
// Pipelined restoring divider: three lanes, one quotient bit per stage.
// Depends on c3s_pkg.
`default_nettype none
module c3s_div_pipe (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    in_valid,
   output logic                                         in_ready,
   input  wire c3s_pkg::c3s_lane_type [2:0]             in_lane,
   input  wire c3s_pkg::c3s_ctl_type                    in_ctl,
   output logic                                         out_valid,
   input  wire logic                                    out_ready,
   output logic [2:0][c3s_pkg::FIELD_W-1:0]             out_quo,
   output c3s_pkg::c3s_ctl_type                         out_ctl
);
   localparam int unsigned N = c3s_pkg::DIV_STEPS;

   c3s_pkg::c3s_lane_type [2:0] stg_ff [1:N];
   c3s_pkg::c3s_ctl_type        ctl_ff [1:N];
   logic [N:1]                  vld_ff;
   logic [N:1]                  vld_in;
   logic [N+1:1]                adv;

   // A stage takes new data when it is empty or its successor moves on.
   assign adv[N+1] = out_ready;
   for (genvar s = 1; s <= N; s++) begin : g_adv
      assign adv[s] = !vld_ff[s] || adv[s+1];
   end
   assign vld_in = {vld_ff[N-1:1], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (adv[N:1] & vld_in) | (~adv[N:1] & vld_ff);
      end
   end

   for (genvar s = 1; s <= N; s++) begin : g_stage
      c3s_pkg::c3s_lane_type [2:0] prev;
      c3s_pkg::c3s_ctl_type        prev_ctl;
      if (s == 1) begin : g_first
         assign prev     = in_lane;
         assign prev_ctl = in_ctl;
      end else begin : g_next
         assign prev     = stg_ff[s-1];
         assign prev_ctl = ctl_ff[s-1];
      end
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            for (int l = 0; l < 3; l++) begin
               stg_ff[s][l] <= c3s_pkg::div_step(prev[l]);
            end
            ctl_ff[s] <= prev_ctl;
         end
      end
   end

   assign in_ready  = adv[1];
   assign out_valid = vld_ff[N];
   assign out_ctl   = ctl_ff[N];
   for (genvar l = 0; l < 3; l++) begin : g_out
      assign out_quo[l] = stg_ff[N][l].quo;
   end
endmodule
`default_nettype wire

>>> tb/tb_cramer_3x3_solver.sv
// Self-checking testbench for the 3x3 Cramer's-rule solver.
// Depends on c3s_pkg, c3s_if and cramer_3x3_solver.
`default_nettype none
module tb_cramer_3x3_solver;

   typedef struct packed {
      c3s_pkg::c3s_word_type tx, ty, tz, ax, ay, az, bx, by, bz, cx, cy, cz;
   } system_type;

   typedef struct packed {
      c3s_pkg::c3s_word_type sx, sy, sz;
      logic                  sing;
   } solution_type;

   localparam int LATENCY = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   error_count = 0;
   bit   hold_off = 1'b0;
   bit   sink_busy = 1'b0;
   solution_type expected_solutions[$];

   c3s_req_if req ();
   c3s_rsp_if rsp ();

   cramer_3x3_solver i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #40000000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic signed [127:0] triple_product(
      logic signed [127:0] p0, p1, p2, q0, q1, q2, r0, r1, r2);
      logic signed [127:0] c0, c1, c2;
      c0 = q1 * r2 - q2 * r1;
      c1 = q2 * r0 - q0 * r2;
      c2 = q0 * r1 - q1 * r0;
      return p0 * c0 + p1 * c1 + p2 * c2;
   endfunction

   // Quotient of (num << 16) / den, truncated toward zero, clamped to 32 bits.
   function automatic c3s_pkg::c3s_word_type scaled_quotient(logic signed [127:0] num,
                                                             logic signed [127:0] den);
      logic signed [127:0] q;
      q = (num <<< 16) / den;
      if (q > 128'sd2147483647) return c3s_pkg::SAT_POS;
      if (q < -128'sd2147483648) return c3s_pkg::SAT_NEG;
      return q[31:0];
   endfunction

   function automatic solution_type solve_system(system_type s);
      logic signed [127:0] t0, t1, t2, a0, a1, a2, b0, b1, b2, c0, c1, c2, det;
      solution_type r;
      t0 = s.tx; t1 = s.ty; t2 = s.tz;
      a0 = s.ax; a1 = s.ay; a2 = s.az;
      b0 = s.bx; b1 = s.by; b2 = s.bz;
      c0 = s.cx; c1 = s.cy; c2 = s.cz;
      det = triple_product(a0, a1, a2, b0, b1, b2, c0, c1, c2);
      r = '0;
      if (det == 0) begin
         r.sing = 1'b1;
      end else begin
         r.sx = scaled_quotient(triple_product(t0, t1, t2, b0, b1, b2, c0, c1, c2), det);
         r.sy = scaled_quotient(triple_product(a0, a1, a2, t0, t1, t2, c0, c1, c2), det);
         r.sz = scaled_quotient(triple_product(a0, a1, a2, b0, b1, b2, t0, t1, t2), det);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      error_count++;
   endtask

   function automatic int short_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // Valid stays high between back-to-back transfers and drops only for a gap.
   task automatic send_system(system_type s);
      int gap;
      gap = short_gap();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      {req.target_x, req.target_y, req.target_z, req.col_a_x, req.col_a_y, req.col_a_z,
       req.col_b_x, req.col_b_y, req.col_b_z, req.col_c_x, req.col_c_y, req.col_c_z} <= s;
      do @(posedge clock); while (!req.ready);
      expected_solutions.push_back(solve_system(s));
      @(negedge clock);
   endtask

   // Response side: random stalls, with an optional long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 9) < 7) || !sink_busy;
      end
   end

   initial begin
      forever begin
         sink_busy = $urandom_range(0, 1);
         repeat ($urandom_range(1, 200)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      solution_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_solutions.size() == 0) begin
            report_mismatch("unexpected transfer", rsp.sol_x, 32'h0);
         end else begin
            want = expected_solutions.pop_front();
            if (rsp.sol_x !== want.sx) report_mismatch("sol_x", rsp.sol_x, want.sx);
            if (rsp.sol_y !== want.sy) report_mismatch("sol_y", rsp.sol_y, want.sy);
            if (rsp.sol_z !== want.sz) report_mismatch("sol_z", rsp.sol_z, want.sz);
            if (rsp.singular !== want.sing)
               report_mismatch("singular", 32'(rsp.singular), 32'(want.sing));
         end
      end
   end

   function automatic c3s_pkg::c3s_word_type random_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? c3s_pkg::SAT_POS : c3s_pkg::SAT_NEG;
         1: return $signed($urandom_range(0, 8)) - 4;
         2: return ($signed($urandom_range(0, 8)) - 4) <<< 16;
         3: return $signed($urandom_range(0, 65535)) - 32768;
         default: return $urandom();
      endcase
   endfunction

   function automatic system_type random_system();
      system_type s;
      s = {random_word(), random_word(), random_word(), random_word(), random_word(),
           random_word(), random_word(), random_word(), random_word(), random_word(),
           random_word(), random_word()};
      // Force a singular system now and then by repeating or zeroing a column.
      case ($urandom_range(0, 9))
         0: {s.cx, s.cy, s.cz} = {s.ax, s.ay, s.az};
         1: {s.bx, s.by, s.bz} = '0;
         default: ;
      endcase
      return s;
   endfunction

   task automatic test_directed();
      localparam c3s_pkg::c3s_word_type ONE = 32'sh0001_0000;
      system_type s;
      // Identity matrix: solution equals the target.
      s = {32'sh0002_0000, -32'sh0003_0000, 32'sh0000_8000,
           ONE, 32'sd0, 32'sd0, 32'sd0, ONE, 32'sd0, 32'sd0, 32'sd0, ONE};
      send_system(s);
      send_system('0);
      send_system({12{c3s_pkg::SAT_NEG}});
      send_system({12{c3s_pkg::SAT_POS}});
      // Tiny determinant with large target overflows both ways.
      s = {c3s_pkg::SAT_POS, c3s_pkg::SAT_NEG, c3s_pkg::SAT_POS, 32'sd1, 32'sd0, 32'sd0,
           32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1};
      send_system(s);
      s = {c3s_pkg::SAT_NEG, c3s_pkg::SAT_POS, c3s_pkg::SAT_NEG, -32'sd1, 32'sd0, 32'sd0,
           32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1};
      send_system(s);
      // Extreme diagonal: large determinant.
      s = {c3s_pkg::SAT_POS, 32'sd1, c3s_pkg::SAT_NEG, c3s_pkg::SAT_NEG, 32'sd0, 32'sd0,
           32'sd0, c3s_pkg::SAT_NEG, 32'sd0, 32'sd0, 32'sd0, c3s_pkg::SAT_POS};
      send_system(s);
      // Singular by two equal columns, with a nonzero target.
      s = {ONE, ONE, ONE, 32'sd5, 32'sd7, -32'sd9, 32'sd5, 32'sd7, -32'sd9, ONE, 32'sd0, ONE};
      send_system(s);
      repeat (10) send_system({12{$urandom()}});
   endtask

   task automatic test_random();
      repeat (1660) send_system(random_system());
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall the input.
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         repeat (120) send_system(random_system());
      join
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_solutions.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   initial begin
      req.valid = 1'b0;
      {req.target_x, req.target_y, req.target_z, req.col_a_x, req.col_a_y, req.col_a_z,
       req.col_b_x, req.col_b_y, req.col_b_z, req.col_c_x, req.col_c_y, req.col_c_z} = '0;
      rsp.ready = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      drain();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
